// ----- hdl/wheel_sync_pid_drive_top_assert.svh -----
// ----------------------------------------------------------------------------
// wheel sync pid drive assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef WHEEL_SYNC_PID_DRIVE_TOP_ASSERT_SVH
`define WHEEL_SYNC_PID_DRIVE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define WSPD_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wspd check failed: same cycle implication");
// next-cycle implication
`define WSPD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wspd check failed: next cycle implication");
`else
`define WSPD_ASSERT_IMPL(name, clk, rst, ante, cons)
`define WSPD_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/wspd_pkg.sv -----
// ----------------------------------------------------------------------------
// wspd_pkg
// widths, register indexes and saturating helpers of the wheel sync drive
// ----------------------------------------------------------------------------
package wspd_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int GAIN_W          = 32;
  localparam int ERR_W           = 32;
  localparam int INTEG_W         = 48;
  localparam int CORR_W          = 24;
  localparam int DRIVE_W         = 16;
  localparam int MS_W            = 16;
  localparam int ACC_W           = 64;
  localparam int FRAC_BITS       = 24;

  localparam int S_TDATA_W  = 96;
  localparam int M_TDATA_W  = 56;
  localparam int CFG_ADDR_W = 2;

  // serial multiplier: radix-4, one 2-bit digit of the multiplier per cycle
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 48;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_DIGITS = MUL_B_W / 2;

  // serial divider: restoring, one quotient bit per cycle
  localparam int DIV_N_W = 32;
  localparam int DIV_D_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_PROP  = 2'd0,
    REG_GAIN_INTEG = 2'd1,
    REG_GAIN_DERIV = 2'd2
  } reg_index_t;

  localparam logic [1:0] TURN_LEFT  = 2'd0;
  localparam logic [1:0] TURN_RIGHT = 2'd2;

  // magnitude product to signed, clamped at +-(2^63-1)
  function automatic logic signed [ACC_W-1:0] mul_apply_sign(
    input logic [MUL_P_W-1:0] mag,
    input logic               neg
  );
    logic [ACC_W-1:0] m;
    if (|mag[MUL_P_W-1:ACC_W-1]) m = {1'b0, {(ACC_W-1){1'b1}}};
    else m = mag[ACC_W-1:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // 64-bit add that clamps at the signed range
  function automatic logic signed [ACC_W-1:0] sat_add64(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

// ----- hdl/wspd_mul.sv -----
// ----------------------------------------------------------------------------
// wspd_mul
// unsigned shift-add multiplier, two multiplier bits per cycle
// ----------------------------------------------------------------------------
module wspd_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wspd_pkg::MUL_A_W-1:0]  mcand,
  input  logic [wspd_pkg::MUL_B_W-1:0]  mplier,
  output logic                          busy,
  output logic [wspd_pkg::MUL_P_W-1:0]  prod
);
  import wspd_pkg::*;

  localparam int HI_W  = MUL_A_W + 2;
  localparam int CNT_W = $clog2(MUL_DIGITS);

  logic [HI_W-1:0]    hi;
  logic [HI_W-1:0]    a1;
  logic [HI_W-1:0]    a3;
  logic [MUL_B_W-1:0] lo;
  logic [CNT_W-1:0]   cnt;
  logic [HI_W-1:0]    addend;
  logic [HI_W:0]      sum;

  always_comb begin
    case (lo[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = a1;
      2'd2:    addend = {a1[HI_W-2:0], 1'b0};
      default: addend = a3;
    endcase
    sum = {1'b0, hi} + {1'b0, addend};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      hi   <= '0;
      lo   <= mplier;
      a1   <= {2'b00, mcand};
      a3   <= {2'b00, mcand} + {1'b0, mcand, 1'b0};
    end else if (busy) begin
      hi  <= {1'b0, sum[HI_W:2]};
      lo  <= {sum[1:0], lo[MUL_B_W-1:2]};
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(MUL_DIGITS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign prod = {hi[MUL_P_W-MUL_B_W-1:0], lo};

endmodule

// ----- hdl/wspd_div.sv -----
// ----------------------------------------------------------------------------
// wspd_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wspd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wspd_pkg::DIV_N_W-1:0]  dividend,
  input  logic [wspd_pkg::DIV_D_W-1:0]  divisor,
  output logic                          busy,
  output logic [wspd_pkg::DIV_N_W-1:0]  quot
);
  import wspd_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W);

  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] dvs;
  logic [DIV_N_W-1:0] q;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_D_W+1:0] diff;
  logic               fits;

  always_comb begin
    diff = {1'b0, rem, q[DIV_N_W-1]} - {2'b00, dvs};
    fits = !diff[DIV_D_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
      dvs  <= divisor;
      q    <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DIV_D_W-1:0] : {rem[DIV_D_W-2:0], q[DIV_N_W-1]};
      q   <= {q[DIV_N_W-2:0], fits};
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DIV_N_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quot = q;

endmodule

// ----- hdl/wheel_sync_pid_drive_top.sv -----
// ----------------------------------------------------------------------------
// wheel_sync_pid_drive_top
// two-wheel drive commands with a pid loop that keeps the wheels in step
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  s_*      in   tdata: base_speed, left_count, right_count, elapsed_ms
//                tuser: turn_mode
//  m_*      out  tdata: left_drive, right_drive, new_correction
//                tuser: zero_interval
//  cfg_*    in   gain_prop, gain_integ, gain_deriv writes, no read-back
//
//  each item takes four passes through the shared radix-4 multiplier, and a
//  new beat is taken only in the idle state; the derivative divide runs
//  alongside the first two products
//  rst is synchronous: clears gains, error history, integral and correction
//  a finished result waits in the output register while the next beat is
//  taken; the sequencer stalls at the finish only while that register is full and not draining
`include "wheel_sync_pid_drive_top_assert.svh"

module wheel_sync_pid_drive_top #(
  parameter int COUNT_WIDTH = wspd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // base_speed[15:0], left_count[47:16], right_count[79:48], elapsed_ms[95:80]
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [wspd_pkg::S_TDATA_W-1:0]   s_tdata,
  // turn_mode[1:0]
  input  logic [1:0]                       s_tuser,
  // left_drive[15:0], right_drive[31:16], new_correction[55:32]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [wspd_pkg::M_TDATA_W-1:0]   m_tdata,
  // zero_interval[0]
  output logic [0:0]                       m_tuser,
  input  logic                             cfg_we,
  input  logic [wspd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [wspd_pkg::GAIN_W-1:0]      cfg_data
);
  import wspd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_EM, S_MP, S_MI, S_MD, S_DONE
  } state_t;

  state_t state;

  // gains and loop state
  logic signed [GAIN_W-1:0]  gain_prop;
  logic signed [GAIN_W-1:0]  gain_integ;
  logic signed [GAIN_W-1:0]  gain_deriv;
  logic signed [ERR_W-1:0]   prev_err;
  logic signed [INTEG_W-1:0] integ;
  logic signed [CORR_W-1:0]  wheel_corr;

  // per-item registers
  logic signed [DRIVE_W-1:0] left_d;
  logic signed [DRIVE_W-1:0] right_d;
  logic signed [ERR_W-1:0]   err_r;
  logic [MS_W-1:0]           ms_r;
  logic                      ms_zero;
  logic                      diff_neg;
  logic                      mul_neg;
  logic signed [ACC_W-1:0]   acc;

  // input field decode
  logic signed [DRIVE_W-1:0] in_speed;
  logic [1:0]                in_mode;
  logic signed [ERR_W-1:0]   in_lc;
  logic signed [ERR_W-1:0]   in_rc;
  logic [MS_W-1:0]           in_ms;

  logic [DRIVE_W:0]          left_sum;
  logic [CORR_W:0]           right_sum;
  logic [DRIVE_W-1:0]        left_sat;
  logic [DRIVE_W-1:0]        right_sat;
  logic [ERR_W:0]            err_sum;
  logic [ERR_W-1:0]          err_sat;

  // derivative numerator and magnitudes for the shared units
  logic [ERR_W:0]            dd;
  logic [ERR_W:0]            dd_mag;
  logic [ERR_W-1:0]          err_mag;
  logic [GAIN_W-1:0]         gp_mag;
  logic [GAIN_W-1:0]         gi_mag;
  logic [GAIN_W-1:0]         gd_mag;
  logic [INTEG_W-1:0]        integ_mag;

  logic [INTEG_W:0]          em_signed;
  logic [INTEG_W+1:0]        integ_sum;
  logic [INTEG_W-1:0]        integ_sat;
  logic signed [ACC_W-1:0]   prod_signed;
  logic signed [ACC_W-FRAC_BITS-1:0] acc_sh;
  logic [ACC_W-FRAC_BITS:0]  corr_sum;
  logic [CORR_W-1:0]         corr_sat;

  logic                      mul_start;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      mul_busy;
  logic [MUL_P_W-1:0]        mul_prod;
  logic                      div_start;
  logic                      div_busy;
  logic [DIV_N_W-1:0]        div_quot;

  assign in_speed = s_tdata[15:0];
  assign in_mode  = s_tuser;
  // counts keep only their low COUNT_WIDTH bits, sign-extended
  assign in_lc    = ERR_W'($signed(s_tdata[16 +: COUNT_WIDTH]));
  assign in_rc    = ERR_W'($signed(s_tdata[48 +: COUNT_WIDTH]));
  assign in_ms    = s_tdata[95:80];

  assign s_tready = (state == S_IDLE);

  always_comb begin
    // the right drive uses the correction held before this beat
    left_sum = (in_mode == TURN_LEFT) ? -{in_speed[DRIVE_W-1], in_speed}
                                      : {in_speed[DRIVE_W-1], in_speed};
    right_sum = {{(CORR_W-DRIVE_W+1){in_speed[DRIVE_W-1]}}, in_speed}
              + {wheel_corr[CORR_W-1], wheel_corr};
    if (in_mode == TURN_RIGHT) right_sum = -right_sum;

    if (left_sum[DRIVE_W] != left_sum[DRIVE_W-1]) begin
      left_sat = left_sum[DRIVE_W] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                   : {1'b0, {(DRIVE_W-1){1'b1}}};
    end else begin
      left_sat = left_sum[DRIVE_W-1:0];
    end

    if (right_sum[CORR_W:DRIVE_W-1] != {(CORR_W-DRIVE_W+2){right_sum[CORR_W]}}) begin
      right_sat = right_sum[CORR_W] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                    : {1'b0, {(DRIVE_W-1){1'b1}}};
    end else begin
      right_sat = right_sum[DRIVE_W-1:0];
    end

    // error is left minus right, clamped to 32 bits
    err_sum = {in_lc[ERR_W-1], in_lc} - {in_rc[ERR_W-1], in_rc};
    if (err_sum[ERR_W] != err_sum[ERR_W-1]) begin
      err_sat = err_sum[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}}
                               : {1'b0, {(ERR_W-1){1'b1}}};
    end else begin
      err_sat = err_sum[ERR_W-1:0];
    end
  end

  always_comb begin
    dd        = {err_r[ERR_W-1], err_r} - {prev_err[ERR_W-1], prev_err};
    dd_mag    = dd[ERR_W] ? -dd : dd;
    err_mag   = err_r[ERR_W-1] ? -err_r : err_r;
    gp_mag    = gain_prop[GAIN_W-1] ? -gain_prop : gain_prop;
    gi_mag    = gain_integ[GAIN_W-1] ? -gain_integ : gain_integ;
    gd_mag    = gain_deriv[GAIN_W-1] ? -gain_deriv : gain_deriv;
    integ_mag = integ[INTEG_W-1] ? -integ : integ;

    // error times ms is below 2^47 in magnitude
    em_signed = mul_neg ? -{1'b0, mul_prod[INTEG_W-1:0]} : {1'b0, mul_prod[INTEG_W-1:0]};
    integ_sum = {{2{integ[INTEG_W-1]}}, integ} + {em_signed[INTEG_W], em_signed};
    if (integ_sum[INTEG_W+1:INTEG_W-1] != {3{integ_sum[INTEG_W+1]}}) begin
      integ_sat = integ_sum[INTEG_W+1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                       : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_sat = integ_sum[INTEG_W-1:0];
    end

    prod_signed = mul_apply_sign(mul_prod, mul_neg);

    // floor shift into correction units, add the held correction, then clamp to 24 bits
    acc_sh   = acc[ACC_W-1:FRAC_BITS];
    corr_sum = {acc_sh[ACC_W-FRAC_BITS-1], acc_sh}
             + (ACC_W-FRAC_BITS+1)'($signed(wheel_corr));
    if (corr_sum[ACC_W-FRAC_BITS:CORR_W-1]
        != {(ACC_W-FRAC_BITS-CORR_W+2){corr_sum[ACC_W-FRAC_BITS]}}) begin
      corr_sat = corr_sum[ACC_W-FRAC_BITS] ? {1'b1, {(CORR_W-1){1'b0}}}
                                           : {1'b0, {(CORR_W-1){1'b1}}};
    end else begin
      corr_sat = corr_sum[CORR_W-1:0];
    end
  end

  // operand steering for the shared multiplier and the divider
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state)
      S_PREP: begin
        mul_start = 1'b1;
        mul_a     = err_mag;
        mul_b     = MUL_B_W'(ms_r);
        div_start = !ms_zero;
      end
      S_EM: begin
        mul_start = !mul_busy;
        mul_a     = gp_mag;
        mul_b     = MUL_B_W'(err_mag);
      end
      S_MP: begin
        mul_start = !mul_busy;
        mul_a     = gi_mag;
        mul_b     = integ_mag;
      end
      S_MI: begin
        mul_start = !mul_busy && !div_busy;
        mul_a     = gd_mag;
        // zero interval drops the derivative term
        mul_b     = ms_zero ? '0 : MUL_B_W'(div_quot);
      end
      default: begin
      end
    endcase
  end

  wspd_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mul_a),
    .mplier (mul_b),
    .busy   (mul_busy),
    .prod   (mul_prod)
  );

  wspd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dd_mag[DIV_N_W-1:0]),
    .divisor  (ms_r),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      gain_prop  <= '0;
      gain_integ <= '0;
      gain_deriv <= '0;
      prev_err   <= '0;
      integ      <= '0;
      wheel_corr <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_index_t'(cfg_addr))
          REG_GAIN_PROP:  gain_prop  <= cfg_data;
          REG_GAIN_INTEG: gain_integ <= cfg_data;
          REG_GAIN_DERIV: gain_deriv <= cfg_data;
          default: begin
          end
        endcase
      end

      // output slot: load a finished item, else drain on a taken beat
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            left_d  <= left_sat;
            right_d <= right_sat;
            err_r   <= err_sat;
            ms_r    <= in_ms;
            ms_zero <= (in_ms == '0);
            state   <= S_PREP;
          end
        end
        S_PREP: begin
          // error times ms and, for a nonzero interval, the derivative divide start here
          diff_neg <= dd[ERR_W];
          prev_err <= err_r;
          mul_neg  <= err_r[ERR_W-1];
          state    <= S_EM;
        end
        S_EM: begin
          if (!mul_busy) begin
            integ   <= integ_sat;
            mul_neg <= gain_prop[GAIN_W-1] ^ err_r[ERR_W-1];
            state   <= S_MP;
          end
        end
        S_MP: begin
          if (!mul_busy) begin
            acc     <= prod_signed;
            mul_neg <= gain_integ[GAIN_W-1] ^ integ[INTEG_W-1];
            state   <= S_MI;
          end
        end
        S_MI: begin
          if (!mul_busy && !div_busy) begin
            acc     <= sat_add64(acc, prod_signed);
            mul_neg <= gain_deriv[GAIN_W-1] ^ diff_neg;
            state   <= S_MD;
          end
        end
        S_MD: begin
          if (!mul_busy) begin
            acc   <= sat_add64(acc, prod_signed);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hand off only when the output register is free or draining
          if (!m_tvalid || m_tready) begin
            m_tdata    <= {corr_sat, right_d, left_d};
            m_tuser    <= ms_zero;
            wheel_corr <= corr_sat;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an accepted beat always starts the sequence
  `WSPD_ASSERT_NEXT(a_accept_starts, clk, rst, s_tvalid && s_tready, state == S_PREP)
  // the derivative product never starts before the quotient is ready
  `WSPD_ASSERT_IMPL(a_quot_ready, clk, rst, state == S_MD, !div_busy)
  // a finished item waits while the output slot is full and not draining
  `WSPD_ASSERT_NEXT(a_done_waits, clk, rst, state == S_DONE && m_tvalid && !m_tready, state == S_DONE && m_tvalid)

endmodule
